// ===== src/hdri_pkg.sv =====
// Shared constants, CORDIC arctangent table and saturation helper for the
// heading dead reckoning integrator.
// No dependencies.
package hdri_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // configuration register indexes
  localparam logic REG_DECLINATION = 1'b0;
  localparam logic REG_ACCEL_SCALE = 1'b1;

  localparam logic [23:0] ACCEL_SCALE_RST = 24'd1023;

  // shift-add multiplier and restoring divider sizes
  localparam int MUL_BITS = 20;
  localparam int DIV_BITS = 60;

  localparam logic [19:0] G_Q16       = 20'd642689;   // 9.80665 in Q16
  localparam logic [21:0] US_PER_S    = 22'd1000000;
  localparam logic [21:0] TWO_US_PER_S = 22'd2000000;

  localparam logic signed [35:0] CORDIC_K_Q30 = 36'sd652032874;

  typedef logic signed [47:0] wide_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] t;
    case (idx)
      5'd0:    t = 32'd536870912;
      5'd1:    t = 32'd316933406;
      5'd2:    t = 32'd167458907;
      5'd3:    t = 32'd85004756;
      5'd4:    t = 32'd42667331;
      5'd5:    t = 32'd21354465;
      5'd6:    t = 32'd10679838;
      5'd7:    t = 32'd5340245;
      5'd8:    t = 32'd2670163;
      5'd9:    t = 32'd1335087;
      5'd10:   t = 32'd667544;
      5'd11:   t = 32'd333772;
      5'd12:   t = 32'd166886;
      5'd13:   t = 32'd83443;
      5'd14:   t = 32'd41721;
      5'd15:   t = 32'd20860;
      5'd16:   t = 32'd10430;
      5'd17:   t = 32'd5215;
      5'd18:   t = 32'd2607;
      5'd19:   t = 32'd1303;
      5'd20:   t = 32'd651;
      5'd21:   t = 32'd325;
      5'd22:   t = 32'd162;
      5'd23:   t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/heading_dead_reckoning_integrator.sv =====
// One transaction at a time. A moving transaction runs a CORDIC vectoring pass
// (none when mag_y is zero) and a rotation pass, then the shared bit-serial unit:
// one multiplier bit or one quotient bit per cycle (20-bit multiplies, 60-bit
// divides). A still transaction goes straight to the output register.
// Reset (synchronous, rst_n low) zeroes velocities, positions and heading, sets
// declination 0 and accel_scale 1023, and empties the output register.
// Top level: compass heading, CORDIC sin/cos and trapezoid integration.
// Depends on hdri_pkg.
module heading_dead_reckoning_integrator #(
  parameter int CORDIC_STEPS = hdri_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = hdri_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_moving,
  input  logic               in_restart,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  input  logic signed [15:0] in_accel_forward,
  input  logic [19:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_heading_angle,
  output logic signed [31:0] out_east_position,
  output logic signed [31:0] out_north_position,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VEC  = 4'd1;
  localparam logic [3:0] S_ROTI = 4'd2;
  localparam logic [3:0] S_ROT  = 4'd3;
  localparam logic [3:0] S_MACC = 4'd4;
  localparam logic [3:0] S_MG   = 4'd5;
  localparam logic [3:0] S_MAX  = 4'd6;
  localparam logic [3:0] S_MDV  = 4'd7;
  localparam logic [3:0] S_DDV  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_MDP  = 4'd10;
  localparam logic [3:0] S_DDP  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam int DN = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
  localparam int UP = (FRAC_BITS > 20) ? FRAC_BITS - 20 : 0;
  localparam logic [43:0] DV_HALF = (DN == 0) ? 44'd0 : (44'd1 << ((DN > 0) ? DN - 1 : 0));

  localparam logic signed [33:0] Z_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] Z_Q31 = 34'sd2147483648;

  // control state
  logic [3:0]         state_r, state_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               axis_r, axis_nxt;
  logic [15:0]        decl_r, decl_nxt;
  logic [23:0]        scale_r, scale_nxt;
  logic signed [31:0] ev_r, ev_nxt, nv_r, nv_nxt, ep_r, ep_nxt, np_r, np_nxt;
  logic [15:0]        head_r, head_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath
  logic signed [15:0] accel_r, accel_nxt;
  logic [19:0]        us_r, us_nxt;
  logic signed [35:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [33:0] cz_r, cz_nxt;
  logic               flip_r, flip_nxt;
  logic [16:0]        s_mag_r, s_mag_nxt, c_mag_r, c_mag_nxt;
  logic               s_neg_r, s_neg_nxt, c_neg_r, c_neg_nxt;
  logic [39:0]        a_mag_r, a_mag_nxt;
  logic               a_neg_r, a_neg_nxt, ax_neg_r, ax_neg_nxt, sum_neg_r, sum_neg_nxt;
  logic signed [31:0] v2_r, v2_nxt;
  logic [39:0]        a_r, a_nxt;
  logic [19:0]        b_r, b_nxt;
  logic [59:0]        p_r, p_nxt;
  logic [20:0]        rem_r, rem_nxt;
  logic [15:0]        out_head_r, out_head_nxt;
  logic signed [31:0] out_east_r, out_east_nxt, out_north_r, out_north_nxt;

  // combinational helpers
  logic               in_fire;
  logic [4:0]         step_i;
  logic               plus;
  logic signed [35:0] dx, dy, x0, y0, cabs, sabs;
  logic signed [33:0] tval, z0;
  logic [59:0]        mul_step, rnd_sum;
  logic [21:0]        r_sh, dsr;
  logic               ge;
  logic [15:0]        raw;
  logic [31:0]        acc_rnd;
  logic [16:0]        acc_abs;
  logic [43:0]        dv_mag;
  logic signed [45:0] dv_s;
  logic signed [31:0] v_old, p_old, v2_w, pos_w;
  logic signed [32:0] vsum;
  logic [32:0]        vsum_abs;
  logic signed [34:0] dp_s;
  logic [35:0]        cabs_rnd, sabs_rnd;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_heading_angle  = out_head_r;
  assign out_east_position  = out_east_r;
  assign out_north_position = out_north_r;

  always_comb begin
    step_i   = 5'(CORDIC_STEPS - int'(cnt_r));
    dx       = cy_r >>> step_i;
    dy       = cx_r >>> step_i;
    tval     = $signed({2'b00, hdri_pkg::atan_turn(step_i)});
    plus     = (state_r == S_VEC) ? (cy_r > 36'sd0) : (cz_r < 34'sd0);
    mul_step = {p_r[58:0], 1'b0} + (b_r[19] ? 60'(a_r) : 60'd0);
    dsr      = (state_r == S_DDV) ? hdri_pkg::US_PER_S : hdri_pkg::TWO_US_PER_S;
    r_sh     = {rem_r, p_r[59]};
    ge       = (r_sh >= dsr);
    x0       = $signed({{4{in_mag_y[15]}}, in_mag_y, 16'h0000});
    y0       = -$signed({{4{in_mag_x[15]}}, in_mag_x, 16'h0000});
    acc_rnd  = cz_r[31:0] + 32'h0000_8000;
    raw      = acc_rnd[31:16];
    z0       = $signed({{2{head_r[15]}}, head_r, 16'h0000});
    cabs     = cx_r[35] ? -cx_r : cx_r;
    sabs     = cy_r[35] ? -cy_r : cy_r;
    cabs_rnd = 36'(cabs) + 36'd8192;
    sabs_rnd = 36'(sabs) + 36'd8192;
    acc_abs  = accel_r[15] ? 17'(-{accel_r[15], accel_r}) : {1'b0, accel_r};
    rnd_sum  = p_r + ((state_r == S_MG) ? 60'd524288 : 60'd32768);
    dv_mag   = ((44'(p_r[39:0]) + DV_HALF) >> DN) << UP;
    dv_s     = ax_neg_r ? -$signed({2'b00, dv_mag}) : $signed({2'b00, dv_mag});
    v_old    = axis_r ? nv_r : ev_r;
    p_old    = axis_r ? np_r : ep_r;
    v2_w     = hdri_pkg::sat32(hdri_pkg::wide_t'(v_old) + hdri_pkg::wide_t'(dv_s));
    vsum     = 33'(v_old) + 33'(v2_r);
    vsum_abs = vsum[32] ? 33'(-vsum) : 33'(vsum);
    dp_s     = sum_neg_r ? -$signed({1'b0, p_r[33:0]}) : $signed({1'b0, p_r[33:0]});
    pos_w    = hdri_pkg::sat32(hdri_pkg::wide_t'(p_old) + hdri_pkg::wide_t'(dp_s));
  end

  always_comb begin
    state_nxt = state_r;   cnt_nxt = cnt_r;       axis_nxt = axis_r;
    decl_nxt = decl_r;     scale_nxt = scale_r;
    ev_nxt = ev_r; nv_nxt = nv_r; ep_nxt = ep_r; np_nxt = np_r;
    head_nxt = head_r;     out_valid_nxt = out_valid_r && !out_ready;
    accel_nxt = accel_r;   us_nxt = us_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; flip_nxt = flip_r;
    s_mag_nxt = s_mag_r; c_mag_nxt = c_mag_r; s_neg_nxt = s_neg_r; c_neg_nxt = c_neg_r;
    a_mag_nxt = a_mag_r; a_neg_nxt = a_neg_r; ax_neg_nxt = ax_neg_r;
    sum_neg_nxt = sum_neg_r; v2_nxt = v2_r;
    a_nxt = a_r; b_nxt = b_r; p_nxt = p_r; rem_nxt = rem_r;
    out_head_nxt = out_head_r; out_east_nxt = out_east_r; out_north_nxt = out_north_r;

    if (cfg_we) begin
      if (cfg_index == hdri_pkg::REG_DECLINATION) begin
        decl_nxt = cfg_wdata[15:0];
      end else begin
        scale_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          accel_nxt = in_accel_forward;
          us_nxt    = in_elapsed_us;
          if (in_restart) begin
            ev_nxt = '0; nv_nxt = '0; ep_nxt = '0; np_nxt = '0; head_nxt = '0;
          end
          if (!in_moving) begin
            ev_nxt = '0; nv_nxt = '0;
            state_nxt = S_DONE;
          end else if (in_mag_y == 16'sd0) begin
            // vector on the x axis: straight half turn or zero
            head_nxt  = ((in_mag_x > 16'sd0) ? 16'h8000 : 16'h0000) - decl_r;
            state_nxt = S_ROTI;
          end else begin
            // fold the left half plane over before vectoring
            cx_nxt    = in_mag_y[15] ? -x0 : x0;
            cy_nxt    = in_mag_y[15] ? -y0 : y0;
            cz_nxt    = in_mag_y[15] ? 34'sh0_8000_0000 : 34'sd0;
            cnt_nxt   = 6'(CORDIC_STEPS);
            state_nxt = S_VEC;
          end
        end
      end
      S_VEC, S_ROT: begin
        if (cnt_r != 6'd0) begin
          cx_nxt  = plus ? cx_r + dx : cx_r - dx;
          cy_nxt  = plus ? cy_r - dy : cy_r + dy;
          cz_nxt  = plus ? cz_r + tval : cz_r - tval;
          cnt_nxt = cnt_r - 6'd1;
        end else if (state_r == S_VEC) begin
          head_nxt  = raw - decl_r;
          state_nxt = S_ROTI;
        end else begin
          c_mag_nxt = cabs_rnd[30:14];
          s_mag_nxt = sabs_rnd[30:14];
          c_neg_nxt = flip_r ^ cx_r[35];
          s_neg_nxt = flip_r ^ cy_r[35];
          a_neg_nxt = accel_r[15];
          a_nxt     = 40'(scale_r);
          b_nxt     = 20'(acc_abs);
          p_nxt     = '0;
          cnt_nxt   = 6'(hdri_pkg::MUL_BITS);
          state_nxt = S_MACC;
        end
      end
      S_ROTI: begin
        // fold into the right half plane; negate the result afterwards
        flip_nxt = 1'b0;
        cz_nxt   = z0;
        if (z0 > Z_Q30) begin
          cz_nxt = z0 - Z_Q31; flip_nxt = 1'b1;
        end else if (z0 < -Z_Q30) begin
          cz_nxt = z0 + Z_Q31; flip_nxt = 1'b1;
        end
        cx_nxt    = hdri_pkg::CORDIC_K_Q30;
        cy_nxt    = '0;
        cnt_nxt   = 6'(CORDIC_STEPS);
        state_nxt = S_ROT;
      end
      S_MACC, S_MG, S_MAX, S_MDV, S_MDP: begin
        if (cnt_r != 6'd0) begin
          p_nxt   = mul_step;
          b_nxt   = {b_r[18:0], 1'b0};
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          p_nxt   = '0;
          cnt_nxt = 6'(hdri_pkg::MUL_BITS);
          case (state_r)
            S_MACC: begin
              a_nxt     = p_r[39:0];
              b_nxt     = hdri_pkg::G_Q16;
              state_nxt = S_MG;
            end
            S_MG: begin
              a_mag_nxt  = rnd_sum[59:20];
              a_nxt      = rnd_sum[59:20];
              b_nxt      = {3'b000, s_mag_r};
              ax_neg_nxt = a_neg_r ^ s_neg_r;
              axis_nxt   = 1'b0;
              state_nxt  = S_MAX;
            end
            S_MAX: begin
              a_nxt     = rnd_sum[55:16];
              b_nxt     = us_r;
              state_nxt = S_MDV;
            end
            S_MDV: begin
              p_nxt     = p_r + 60'd500000;
              rem_nxt   = '0;
              cnt_nxt   = 6'(hdri_pkg::DIV_BITS);
              state_nxt = S_DDV;
            end
            default: begin
              p_nxt     = p_r + 60'd1000000;
              rem_nxt   = '0;
              cnt_nxt   = 6'(hdri_pkg::DIV_BITS);
              state_nxt = S_DDP;
            end
          endcase
        end
      end
      S_DDV, S_DDP: begin
        if (cnt_r != 6'd0) begin
          p_nxt   = {p_r[58:0], ge};
          rem_nxt = ge ? 21'(r_sh - dsr) : r_sh[20:0];
          cnt_nxt = cnt_r - 6'd1;
        end else if (state_r == S_DDV) begin
          v2_nxt    = v2_w;
          state_nxt = S_SUM;
        end else begin
          if (axis_r) begin
            np_nxt = pos_w; nv_nxt = v2_r;
            state_nxt = S_DONE;
          end else begin
            ep_nxt = pos_w; ev_nxt = v2_r;
            axis_nxt   = 1'b1;
            a_nxt      = a_mag_r;
            b_nxt      = {3'b000, c_mag_r};
            ax_neg_nxt = a_neg_r ^ c_neg_r;
            p_nxt      = '0;
            cnt_nxt    = 6'(hdri_pkg::MUL_BITS);
            state_nxt  = S_MAX;
          end
        end
      end
      S_SUM: begin
        a_nxt       = 40'(vsum_abs);
        b_nxt       = us_r;
        sum_neg_nxt = vsum[32];
        p_nxt       = '0;
        cnt_nxt     = 6'(hdri_pkg::MUL_BITS);
        state_nxt   = S_MDP;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_head_nxt  = head_r;
          out_east_nxt  = ep_r;
          out_north_nxt = np_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  cnt_r <= '0;  axis_r <= 1'b0;
      decl_r <= '0;       scale_r <= hdri_pkg::ACCEL_SCALE_RST;
      ev_r <= '0; nv_r <= '0; ep_r <= '0; np_r <= '0;
      head_r <= '0;       out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; axis_r <= axis_nxt;
      decl_r <= decl_nxt;   scale_r <= scale_nxt;
      ev_r <= ev_nxt; nv_r <= nv_nxt; ep_r <= ep_nxt; np_r <= np_nxt;
      head_r <= head_nxt;   out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    accel_r <= accel_nxt; us_r <= us_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; flip_r <= flip_nxt;
    s_mag_r <= s_mag_nxt; c_mag_r <= c_mag_nxt; s_neg_r <= s_neg_nxt; c_neg_r <= c_neg_nxt;
    a_mag_r <= a_mag_nxt; a_neg_r <= a_neg_nxt; ax_neg_r <= ax_neg_nxt;
    sum_neg_r <= sum_neg_nxt; v2_r <= v2_nxt;
    a_r <= a_nxt; b_r <= b_nxt; p_r <= p_nxt; rem_r <= rem_nxt;
    out_head_r <= out_head_nxt; out_east_r <= out_east_nxt; out_north_r <= out_north_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing the sequence");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(hdri_pkg::DIV_BITS))
    else $error("step counter out of range");

  a_sum_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> $past(state_r == S_DDV))
    else $error("velocity sum entered out of order");

endmodule

// ===== sim/tb_heading_dead_reckoning_integrator.sv =====
// Self-checking testbench for heading_dead_reckoning_integrator: compass heading,
// CORDIC sin/cos and trapezoid integration are predicted and every result checked.
// Depends on hdri_pkg and the block's top level.
`timescale 1ns / 100ps

class drift_scoreboard;
  localparam int STEPS = 16;
  localparam longint G_Q16 = 642689;
  localparam longint K_Q30 = 652032874;

  longint declination;
  longint accel_scale;
  longint vel_e, vel_n, pos_e, pos_n;
  longint heading;
  logic [79:0] pending_fixes[$];
  int mismatches;
  int results_seen;
  int moving_seen;

  function void clear_state();
    vel_e = 0; vel_n = 0; pos_e = 0; pos_n = 0; heading = 0;
  endfunction

  function void power_on();
    declination = 0;
    accel_scale = 1023;
    clear_state();
    mismatches = 0;
    results_seen = 0;
    moving_seen = 0;
  endfunction

  function longint atan_step(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
    return t[i];
  endfunction

  function longint round_shift(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    if (s == 0) return v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function longint round_div(longint v, longint d);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + d / 2) / d;
    return v < 0 ? -m : m;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint compass_angle(longint x, longint y);
    logic [31:0] acc;
    longint dx, dy;
    acc = 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      x = -x; y = -y; acc = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; acc += 32'(atan_step(i));
      end else begin
        x -= dx; y += dy; acc -= 32'(atan_step(i));
      end
    end
    acc = acc + 32'h8000;
    return longint'(acc[31:16]);
  endfunction

  function void sin_cos(longint h, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = (h & 16'hffff) << 16;
    x = K_Q30; y = 0; flip = 0;
    if (z >= (longint'(1) << 31)) z -= longint'(1) << 32;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31; flip = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = round_shift(x, 14);
    s = round_shift(y, 14);
  endfunction

  // one axis of trapezoid integration; dv is Q20 taken down to Q16
  function void trapezoid(longint a, longint us, inout longint vel, inout longint pos);
    longint dv, v2;
    dv = round_shift(round_div(a * us, 1000000), 4);
    v2 = clamp32(vel + dv);
    pos = clamp32(pos + round_div((vel + v2) * us, 2000000));
    vel = v2;
  endfunction

  function void note_sample(bit moving, bit restart, logic signed [15:0] mx,
                            logic signed [15:0] my, logic signed [15:0] af,
                            logic [19:0] us);
    longint raw, s, c, a;
    if (restart) clear_state();
    if (moving) begin
      moving_seen++;
      if (my == 0) raw = (mx > 0) ? 32768 : 0;
      else raw = compass_angle(longint'(my), -longint'(mx));
      heading = (raw - declination) & 16'hffff;
      sin_cos(heading, s, c);
      a = round_shift(longint'(af) * accel_scale * G_Q16, 20);
      trapezoid(round_shift(a * s, 16), longint'(us), vel_e, pos_e);
      trapezoid(round_shift(a * c, 16), longint'(us), vel_n, pos_n);
    end else begin
      vel_e = 0; vel_n = 0;
    end
    pending_fixes.push_back({heading[15:0], pos_e[31:0], pos_n[31:0]});
  endfunction

  function void check_fix(logic [15:0] hd, logic [31:0] pe, logic [31:0] pn);
    logic [79:0] want;
    results_seen++;
    if (pending_fixes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result hd=%0d", hd);
      return;
    end
    want = pending_fixes.pop_front();
    if (want !== {hd, pe, pn}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: fix %0d exp hd=%0d e=%0d n=%0d got hd=%0d e=%0d n=%0d",
                 results_seen, want[79:64], $signed(want[63:32]), $signed(want[31:0]),
                 hd, $signed(pe), $signed(pn));
    end
  endfunction
endclass

module tb_heading_dead_reckoning_integrator;

  localparam int LATENCY = 2 * hdri_pkg::CORDIC_STEPS_DEF + 419;
  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_moving, in_restart;
  logic signed [15:0] in_mag_x, in_mag_y, in_accel_forward;
  logic [19:0] in_elapsed_us;
  logic out_valid, out_ready;
  logic [15:0] out_heading_angle;
  logic signed [31:0] out_east_position, out_north_position;
  logic cfg_we, cfg_index;
  logic [23:0] cfg_wdata;

  drift_scoreboard board;
  int idle_cycles;
  bit hold_off;

  heading_dead_reckoning_integrator dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_sample(in_moving, in_restart, in_mag_x, in_mag_y, in_accel_forward,
                        in_elapsed_us);
    if (rst_n && out_valid && out_ready)
      board.check_fix(out_heading_angle, out_east_position, out_north_position);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("heading_dead_reckoning_integrator test failed");
      $finish;
    end
  end

  // receiver: random stalls, with one long hold-off on request
  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) out_ready <= 0;
      else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 1) == 0);
      else out_ready <= 1;
      @(negedge clk);
    end
  end

  task automatic send_sample(bit mv, bit rs, logic [15:0] mx, logic [15:0] my,
                             logic [15:0] af, logic [19:0] us);
    in_valid <= 1;
    in_moving <= mv; in_restart <= rs;
    in_mag_x <= mx; in_mag_y <= my; in_accel_forward <= af; in_elapsed_us <= us;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
  endtask

  task automatic drain();
    pause_sender();
    while (board.pending_fixes.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == hdri_pkg::REG_DECLINATION) board.declination = longint'($signed(val[15:0]));
    else board.accel_scale = longint'(val);
  endtask

  task automatic random_burst(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        pause_sender();
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      send_sample($urandom_range(0, 9) != 0, $urandom_range(0, 30) == 0,
                  16'($urandom), ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom),
                  16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000)));
    end
  endtask

  initial begin
    board = new();
    board.power_on();
    rst_n = 0; hold_off = 0; idle_cycles = 0;
    in_valid = 0; in_moving = 0; in_restart = 0;
    in_mag_x = 0; in_mag_y = 0; in_accel_forward = 0; in_elapsed_us = 0;
    cfg_we = 0; cfg_index = hdri_pkg::REG_DECLINATION; cfg_wdata = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: field extremes, zero my both ways, negative my, still, restart
    send_sample(1, 0, 16'h7fff, 16'h0000, 16'h7fff, 20'd1000);
    send_sample(1, 0, 16'h8000, 16'h0000, 16'h8000, 20'd1000);
    send_sample(1, 0, 16'h0000, 16'h0000, 16'h0001, 20'hfffff);
    send_sample(1, 0, 16'h0100, 16'h8000, 16'h7fff, 20'hfffff);
    send_sample(1, 0, 16'hff00, 16'h7fff, 16'h7fff, 20'hfffff);
    send_sample(1, 0, 16'h1234, 16'hedcb, 16'h8000, 20'd0);
    send_sample(0, 0, 16'hffff, 16'hffff, 16'hffff, 20'hfffff);
    send_sample(1, 1, 16'h0000, 16'h4000, 16'h4000, 20'd2000);
    send_sample(0, 1, 16'h5555, 16'haaaa, 16'h5555, 20'haaaaa);
    // saturation: max scale, long steps
    drain();
    write_reg(hdri_pkg::REG_ACCEL_SCALE, 24'hffffff);
    write_reg(hdri_pkg::REG_DECLINATION, 24'h007fff);
    for (int i = 0; i < 8; i++) send_sample(1, 0, 16'h0000, 16'h7fff, 16'h7fff, 20'hfffff);
    for (int i = 0; i < 4; i++) send_sample(1, 0, 16'h0000, 16'h8001, 16'h8000, 20'hfffff);
    drain();
    write_reg(hdri_pkg::REG_DECLINATION, 24'h008000);
    write_reg(hdri_pkg::REG_ACCEL_SCALE, 24'd0);
    send_sample(1, 1, 16'h7fff, 16'h0001, 16'h7fff, 20'd500);
    send_sample(1, 0, 16'h8000, 16'hffff, 16'h7fff, 20'd500);

    // random phases across settings; long receiver stall in the first
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(hdri_pkg::REG_DECLINATION, (ph == 3) ? 24'h0 : 24'($urandom));
      write_reg(hdri_pkg::REG_ACCEL_SCALE, (ph == 1) ? 24'd1023 : 24'($urandom));
      if (ph == 0) begin
        fork
          begin
            hold_off = 1;
            repeat (3 * LATENCY) @(negedge clk);
            hold_off = 0;
          end
          random_burst(6);
        join
      end
      random_burst(270);
    end
    drain();

    $display("Checked %0d results (%0d moving samples) over several register settings.",
             board.results_seen, board.moving_seen);
    if (board.mismatches == 0 && board.pending_fixes.size() == 0) begin
      $display("heading_dead_reckoning_integrator test passed");
    end else begin
      $display("%0d mismatches, %0d outstanding", board.mismatches,
               board.pending_fixes.size());
      $display("heading_dead_reckoning_integrator test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/hdri_pkg.sv
src/heading_dead_reckoning_integrator.sv
sim/tb_heading_dead_reckoning_integrator.sv
